// ===== design/rtt_pkg.sv =====
// Shared types, codes and character classes for the rule text tokenizer.
`default_nettype none

package rtt_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] pos_t;
  typedef logic [62:0] ival_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_COLON   = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_IDENT   = 3'd5,
    MODE_DROP    = 3'd6
  } mode_t;

  localparam logic [3:0] KIND_END        = 4'd0;
  localparam logic [3:0] KIND_IDENT      = 4'd1;
  localparam logic [3:0] KIND_STRING     = 4'd2;
  localparam logic [3:0] KIND_INTEGER    = 4'd3;
  localparam logic [3:0] KIND_LPAREN     = 4'd4;
  localparam logic [3:0] KIND_RPAREN     = 4'd5;
  localparam logic [3:0] KIND_LBRACKET   = 4'd6;
  localparam logic [3:0] KIND_RBRACKET   = 4'd7;
  localparam logic [3:0] KIND_COMMA      = 4'd8;
  localparam logic [3:0] KIND_DOT        = 4'd9;
  localparam logic [3:0] KIND_COLON_DASH = 4'd10;
  localparam logic [3:0] KIND_SLASH      = 4'd11;
  localparam logic [3:0] KIND_EQUALS     = 4'd12;
  localparam logic [3:0] KIND_AT         = 4'd13;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd2;

  localparam byte_t CH_NUL     = 8'h00;
  localparam byte_t CH_HASH    = 8'h23;
  localparam byte_t CH_LF      = 8'h0A;
  localparam byte_t CH_QUOTE   = 8'h22;
  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_DASH    = 8'h2D;
  localparam byte_t CH_UNDER   = 8'h5F;
  localparam byte_t CH_DOT     = 8'h2E;
  localparam byte_t CH_SPACE   = 8'h20;

  localparam ival_t INT_MAX63  = {63{1'b1}};
  localparam pos_t  POS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] err;
    pos_t       start;
    pos_t       len;
    pos_t       line;
    ival_t      value;
    logic       last;
  } result_t;

  function automatic logic is_digit(byte_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(byte_t b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_ident_byte(byte_t b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER) || (b == CH_COLON) ||
           (b == CH_DOT) || (b == CH_DASH);
  endfunction

  function automatic logic is_space(byte_t b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Single-byte punctuation; KIND_END means not punctuation.
  function automatic logic [3:0] punct_kind(byte_t b);
    logic [3:0] k;
    k = KIND_END;
    unique case (b)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h2C:   k = KIND_COMMA;
      8'h2E:   k = KIND_DOT;
      8'h2F:   k = KIND_SLASH;
      8'h3D:   k = KIND_EQUALS;
      8'h40:   k = KIND_AT;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/rule_text_tokenizer_top.sv =====
// Rule text tokenizer: byte stream in, token stream out.
`default_nettype none

// Rule text tokenizer. Takes one text byte per request on the in_ side
// (byte 0 ends the text) and returns token requests on the out_ side:
// punctuation, ':-', quoted strings, decimal integers (saturating at
// 2^63-1), identifiers, and an end token after the end byte. Whitespace
// and '#' comments are skipped; only LF counts a line. An unterminated
// string gives an error token at the end byte; an unexpected byte gives
// one, after which bytes are dropped up to and including the end byte.
// Each byte is scanned in the cycle it is accepted, straight from the
// scanner state registers, and its results (zero, one or two) go into a
// four-entry result queue that drives the out_ ports from registers. One
// byte is taken per clock for as long as the queue has two free entries;
// a byte that closes a token and emits another gives two results, so the
// sustained rate is bounded by the downstream consumer at one token per
// clock. Offsets saturate at min(TEXT_BYTES-1, 65535), lines at 65535.
module rule_text_tokenizer_top #(
  parameter int TEXT_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] byte_value
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [111:0] out_tdata,  // [15:0] start_offset, [31:16] token_length,
                                        // [47:32] line_number, [110:48] integer_value,
                                        // [111] zero
  output      logic [5:0]   out_tuser,  // [3:0] token_kind, [5:4] error_code
  output      logic         out_tlast   // last_of_run
);
  import rtt_pkg::*;

  localparam logic [15:0] OFFSET_MAX =
    (TEXT_BYTES - 1 > 65535) ? 16'hFFFF : 16'(TEXT_BYTES - 1);
  localparam int QDEPTH = 4;

  // scanner state
  mode_t mode_r, mode_nxt;
  pos_t  offset_r, offset_nxt;
  pos_t  line_r, line_nxt;
  pos_t  tstart_r, tstart_nxt;
  pos_t  tline_r, tline_nxt;
  ival_t num_r, num_nxt;

  // result queue, entry 0 is the head
  result_t     q_r [QDEPTH];
  result_t     q_nxt [QDEPTH];
  logic [2:0]  cnt_r, cnt_nxt;

  logic        accept, pop;
  byte_t       b;
  result_t     res0, res1;
  logic [1:0]  nres;

  // scan helpers
  logic        fresh_go;
  logic        fresh_emit;
  result_t     fresh_res;
  mode_t       fresh_mode;
  logic        pend_emit;
  result_t     pend_res;
  logic        line_inc;
  pos_t        span;
  logic [3:0]  pk;
  logic [66:0] num_x10;
  ival_t       num_step;

  assign b      = in_tdata;
  assign accept = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  assign in_tready  = (cnt_r <= 3'd2);
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {1'b0, q_r[0].value, q_r[0].line, q_r[0].len, q_r[0].start};
  assign out_tuser  = {q_r[0].err, q_r[0].kind};
  assign out_tlast  = q_r[0].last;

  assign span = (offset_r >= tstart_r) ? (offset_r - tstart_r) : 16'd0;
  assign pk   = punct_kind(b);

  // value*10 + digit, shift-add; saturate when it passes 2^63-1
  assign num_x10  = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {63'd0, b[3:0]};
  assign num_step = (num_x10 > {4'd0, INT_MAX63}) ? INT_MAX63 : num_x10[62:0];

  // Outcome of scanning the byte as the start of a new token.
  always_comb begin
    fresh_emit = 1'b0;
    fresh_mode = MODE_IDLE;
    fresh_res  = '{kind: KIND_END, err: ERR_NONE, start: offset_r, len: 16'd0,
                   line: line_r, value: '0, last: 1'b0};
    priority if (b == CH_NUL) begin
      fresh_emit = 1'b1;
    end else if (b == CH_HASH) begin
      fresh_mode = MODE_COMMENT;
    end else if (is_space(b)) begin
      fresh_mode = MODE_IDLE;
    end else if (pk != KIND_END) begin
      fresh_emit     = 1'b1;
      fresh_res.kind = pk;
      fresh_res.len  = 16'd1;
    end else if (b == CH_COLON) begin
      fresh_mode = MODE_COLON;
    end else if (b == CH_QUOTE) begin
      fresh_mode = MODE_STRING;
    end else if (is_digit(b)) begin
      fresh_mode = MODE_NUMBER;
    end else if (is_ident_byte(b)) begin
      fresh_mode = MODE_IDENT;
    end else begin
      fresh_emit    = 1'b1;
      fresh_res.err = ERR_UNEXPECTED;
      fresh_mode    = MODE_DROP;
    end
  end

  // Per-mode scan of the accepted byte.
  always_comb begin
    fresh_go  = 1'b0;
    pend_emit = 1'b0;
    pend_res  = '{kind: KIND_IDENT, err: ERR_NONE, start: tstart_r, len: span,
                  line: tline_r, value: '0, last: 1'b0};
    line_inc  = 1'b0;
    mode_nxt  = mode_r;
    num_nxt   = num_r;
    unique case (mode_r)
      MODE_COMMENT: begin
        if (b == CH_NUL) begin
          fresh_go = 1'b1;
        end else if (b == CH_LF) begin
          line_inc = 1'b1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_COLON: begin
        if (b == CH_DASH) begin
          pend_emit     = 1'b1;
          pend_res.kind = KIND_COLON_DASH;
          pend_res.len  = span + 16'd1;
          mode_nxt      = MODE_IDLE;
        end else if (is_ident_byte(b)) begin
          mode_nxt = MODE_IDENT;
        end else begin
          pend_emit = 1'b1;
          fresh_go  = 1'b1;
        end
      end
      MODE_STRING: begin
        if (b == CH_NUL) begin
          pend_emit      = 1'b1;
          pend_res.kind  = KIND_END;
          pend_res.err   = ERR_UNTERMINATED;
          pend_res.start = offset_r;
          pend_res.len   = 16'd0;
          pend_res.line  = line_r;
        end else if (b == CH_QUOTE) begin
          pend_emit     = 1'b1;
          pend_res.kind = KIND_STRING;
          mode_nxt      = MODE_IDLE;
        end else if (b == CH_LF) begin
          line_inc = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin
          num_nxt = num_step;
        end else begin
          pend_emit      = 1'b1;
          pend_res.kind  = KIND_INTEGER;
          pend_res.value = num_r;
          num_nxt        = '0;
          fresh_go       = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!is_ident_byte(b)) begin
          pend_emit = 1'b1;
          fresh_go  = 1'b1;
        end
      end
      MODE_DROP: begin
        mode_nxt = MODE_DROP;
      end
      default: begin
        fresh_go = 1'b1;
      end
    endcase

    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    if (fresh_go) begin
      mode_nxt = fresh_mode;
      if (b == CH_LF) begin
        line_inc = 1'b1;
      end
      if (fresh_mode == MODE_COLON || fresh_mode == MODE_NUMBER ||
          fresh_mode == MODE_IDENT) begin
        tstart_nxt = offset_r;
        tline_nxt  = line_r;
      end else if (fresh_mode == MODE_STRING) begin
        tstart_nxt = (offset_r < OFFSET_MAX) ? offset_r + 16'd1 : OFFSET_MAX;
        tline_nxt  = line_r;
      end
      if (fresh_mode == MODE_NUMBER) begin
        num_nxt = {59'd0, b[3:0]};
      end
    end

    line_nxt   = (line_inc && line_r < POS_MAX) ? line_r + 16'd1 : line_r;
    offset_nxt = (offset_r < OFFSET_MAX) ? offset_r + 16'd1 : offset_r;

    // end byte always returns the scanner to its reset state
    if (b == CH_NUL) begin
      mode_nxt   = MODE_IDLE;
      offset_nxt = 16'd0;
      line_nxt   = 16'd1;
      tstart_nxt = 16'd0;
      tline_nxt  = 16'd1;
      num_nxt    = '0;
    end

    // pack up to two results in order
    res0 = pend_emit ? pend_res : fresh_res;
    res1 = fresh_res;
    if (pend_emit && fresh_go && fresh_emit) begin
      nres = 2'd2;
    end else if (pend_emit || (fresh_go && fresh_emit)) begin
      nres = 2'd1;
    end else begin
      nres = 2'd0;
    end
    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  // Result queue: shift on pop, append at the tail.
  always_comb begin
    logic [2:0] base;
    logic [1:0] push;
    push = accept ? nres : 2'd0;
    base = cnt_r - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (push != 2'd0 && 3'(i) == base) begin
        q_nxt[i] = res0;
      end else if (push == 2'd2 && 3'(i) == base + 3'd1) begin
        q_nxt[i] = res1;
      end else if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[(i < QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    cnt_nxt = base + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      offset_r <= 16'd0;
      line_r   <= 16'd1;
      tstart_r <= 16'd0;
      tline_r  <= 16'd1;
      num_r    <= '0;
      cnt_r    <= 3'd0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        offset_r <= offset_nxt;
        line_r   <= line_nxt;
        tstart_r <= tstart_nxt;
        tline_r  <= tline_nxt;
        num_r    <= num_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

`default_nettype wire
